/* rtl/core/i468_pkg.sv */
// ----------------------------------------------------------------------------
// i468_pkg - shared types and constants for the 468 noise meter
// Coefficients, state word layout, sequencer states and multiply requests.
// ----------------------------------------------------------------------------
`default_nettype none

package i468_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_ATTACK = 2'd0,
    CFG_FAST_DECAY  = 2'd1,
    CFG_SLOW_ATTACK = 2'd2,
    CFG_SLOW_DECAY  = 2'd3
  } cfg_idx_t;

  localparam logic [31:0] RST_FAST_ATTACK = 32'd59950585;
  localparam logic [31:0] RST_FAST_DECAY  = 32'd313175;
  localparam logic [31:0] RST_SLOW_ATTACK = 32'd590558;
  localparam logic [31:0] RST_SLOW_DECAY  = 32'd58161;

  // Filter coefficients, signed Q2.30, tuned for 48 kHz
  localparam logic signed [31:0] K_WHP = 32'sd415701477;
  localparam logic signed [31:0] K_A11 = -32'sd903695490;
  localparam logic signed [31:0] K_A12 = 32'sd327473540;
  localparam logic signed [31:0] K_A21 = -32'sd705236228;
  localparam logic signed [31:0] K_A22 = 32'sd254841809;
  localparam logic signed [31:0] K_A31 = -32'sd363392416;
  localparam logic signed [31:0] K_A32 = 32'sd469834085;
  localparam logic signed [31:0] K_B30 = 32'sd1058795306;
  localparam logic signed [31:0] K_B31 = 32'sd588908618;
  localparam logic signed [31:0] K_B32 = -32'sd88546289;

  // Saturation limits of the Q8.32 state, held in a widened accumulator
  localparam logic signed [43:0] S40_MAX_W = 44'sh07F_FFFF_FFFF;
  localparam logic signed [43:0] S40_MIN_W = 44'shF80_0000_0000;
  localparam logic signed [39:0] S40_MAX   = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] S40_MIN   = 40'sh80_0000_0000;

  // Output limits, Q5.23
  localparam logic [30:0] OUT_POS_MAX = 31'd134217727;
  localparam logic [30:0] OUT_NEG_MAX = 31'd134217728;

  // Per-channel state word
  typedef struct packed {
    logic signed [39:0] hp;
    logic signed [39:0] s1a;
    logic signed [39:0] s1b;
    logic signed [39:0] s2a;
    logic signed [39:0] s2b;
    logic signed [39:0] s3a;
    logic signed [39:0] s3b;
    logic [39:0]        zf;
    logic [39:0]        zs;
  } ch_state_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic [39:0] mag;
    logic [31:0] coef;
    logic        neg;
    logic        dmode;   // 1: detector product, 0: filter product
  } mul_req_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_HP,
    ST_A11, ST_A12, ST_A21, ST_A22, ST_A31, ST_A32,
    ST_B31, ST_B30, ST_B32,
    ST_FD, ST_SD, ST_FA, ST_FADD, ST_SA, ST_SADD,
    ST_FIN
  } seq_state_t;

  function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
    logic signed [39:0] r;
    if (v > S40_MAX_W)      r = S40_MAX;
    else if (v < S40_MIN_W) r = S40_MIN;
    else                    r = v[39:0];
    return r;
  endfunction

  // Filter product: sign and magnitude split
  function automatic mul_req_t mk_cmul(input logic signed [39:0] s,
                                       input logic signed [31:0] c);
    mul_req_t r;
    r.neg   = s[39] ^ c[31];
    r.mag   = s[39] ? 40'(-s) : s;
    r.coef  = c[31] ? 32'(-c) : c;
    r.dmode = 1'b0;
    return r;
  endfunction

  // Detector product: unsigned value times Q0.32 rate
  function automatic mul_req_t mk_dmul(input logic [39:0] v, input logic [31:0] k);
    mul_req_t r;
    r.neg   = 1'b0;
    r.mag   = v;
    r.coef  = k;
    r.dmode = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/itur468_noise_meter_top.sv */
// ----------------------------------------------------------------------------
// itur468_noise_meter_top - 468 weighting filter and quasi-peak meter
// Per-channel filter and detector state in one memory, one shared multiplier.
// ----------------------------------------------------------------------------
//  Port group | Direction | Carries
//  in_*       | input     | channel number and Q1.23 sample
//  out_*      | output    | channel, weighted Q5.23 value, slow level Q5.23
//  cfg_*      | input     | detector attack/decay rates, write only
//
//  An in-range transaction raises out_valid from ST_FIN once the fourteen
//  products have run one after another through the multiplier; the next
//  input can be taken once the sequencer is back in ST_IDLE. A channel at or
//  beyond CHANNELS skips the products and goes straight to ST_FIN.
//  Reset is synchronous; channel state reads as zero until first written.
//  A waiting result does not block the next input; the sequencer only holds
//  in its final cycle if the previous result has not been taken yet.
`default_nettype none

module itur468_noise_meter_top
  import i468_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_channel,
  input  wire logic signed [23:0]    in_sample,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_channel_out,
  output logic signed [27:0]         out_weighted,
  output logic [26:0]                out_level,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]           cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [31:0] fast_attack_r, fast_decay_r, slow_attack_r, slow_decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_attack_r <= RST_FAST_ATTACK;
      fast_decay_r  <= RST_FAST_DECAY;
      slow_attack_r <= RST_SLOW_ATTACK;
      slow_decay_r  <= RST_SLOW_DECAY;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FAST_ATTACK: fast_attack_r <= cfg_data;
        CFG_FAST_DECAY:  fast_decay_r  <= cfg_data;
        CFG_SLOW_ATTACK: slow_attack_r <= cfg_data;
        CFG_SLOW_DECAY:  slow_decay_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  seq_state_t state_r, state_nxt;
  logic       in_acc;
  logic       in_range;
  logic       fin_go;
  logic       out_valid_r;

  assign in_acc   = in_valid && in_ready;
  assign in_range = int'(in_channel) < CHANNELS;
  assign fin_go   = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = in_range ? ST_LOAD : ST_FIN;
      ST_LOAD: state_nxt = ST_HP;
      ST_HP:   state_nxt = ST_A11;
      ST_A11:  state_nxt = ST_A12;
      ST_A12:  state_nxt = ST_A21;
      ST_A21:  state_nxt = ST_A22;
      ST_A22:  state_nxt = ST_A31;
      ST_A31:  state_nxt = ST_A32;
      ST_A32:  state_nxt = ST_B31;
      ST_B31:  state_nxt = ST_B30;
      ST_B30:  state_nxt = ST_B32;
      ST_B32:  state_nxt = ST_FD;
      ST_FD:   state_nxt = ST_SD;
      ST_SD:   state_nxt = ST_FA;
      ST_FA:   state_nxt = ST_FADD;
      ST_FADD: state_nxt = ST_SA;
      ST_SA:   state_nxt = ST_SADD;
      ST_SADD: state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State memory with per-entry valid bits
  ch_state_t        mem [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  ch_state_t        rdata_r;
  logic             vld_r;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    chaddr_r;
  logic             inrange_r;
  logic             mem_we;
  ch_state_t        wword;

  assign raddr  = AW'(in_channel);
  assign mem_we = (state_r == ST_FIN) && fin_go && inrange_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_range) begin
      rdata_r <= mem[raddr];
      vld_r   <= valid_r[raddr];
    end
    if (mem_we) mem[chaddr_r] <= wword;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      valid_r <= '0;
    else if (mem_we) valid_r[chaddr_r] <= 1'b1;
  end

  // Working registers
  logic [2:0]         ch_r;
  logic signed [39:0] x_r, hp_r, s1a_r, s1b_r, s2a_r, s2b_r, s3a_r, s3b_r, y_r;
  logic [39:0]        zf_r, zs_r;
  logic signed [43:0] acc_r;
  logic               fa_r, sa_r;

  assign wword = '{hp: hp_r, s1a: s1a_r, s1b: s1b_r, s2a: s2a_r, s2b: s2b_r,
                   s3a: s3a_r, s3b: s3b_r, zf: zf_r, zs: zs_r};

  // Shared multiplier
  mul_req_t           mreq;
  logic signed [41:0] prod;

  i468_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  // Datapath terms around the multiplier result
  logic signed [43:0] p_w;
  logic signed [39:0] hp_n, x_hp, acc_sub_sat, acc_add_sat;
  logic signed [43:0] x_sub, acc_add;
  logic [39:0]        rect;
  ch_state_t          ld;

  always_comb begin
    p_w         = 44'(prod);
    hp_n        = sat40(44'(hp_r) + p_w);
    x_hp        = sat40(44'(x_r) - 44'(hp_n));
    x_sub       = 44'(x_r) - p_w;
    acc_sub_sat = sat40(acc_r - p_w);
    acc_add     = acc_r + p_w;
    acc_add_sat = sat40(acc_add);
    if (!y_r[39])          rect = y_r;
    else if (y_r == S40_MIN) rect = S40_MAX;
    else                   rect = 40'(-y_r);
    ld = vld_r ? rdata_r : '0;
  end

  // Multiplier operand selection
  always_comb begin
    mreq = '0;
    unique case (state_r)
      ST_HP:   mreq = mk_cmul(sat40(44'(x_r) - 44'(hp_r)), K_WHP);
      ST_A11:  mreq = mk_cmul(s1a_r, K_A11);
      ST_A12:  mreq = mk_cmul(s1b_r, K_A12);
      ST_A21:  mreq = mk_cmul(s2a_r, K_A21);
      ST_A22:  mreq = mk_cmul(s2b_r, K_A22);
      ST_A31:  mreq = mk_cmul(s3a_r, K_A31);
      ST_A32:  mreq = mk_cmul(s3b_r, K_A32);
      ST_B31:  mreq = mk_cmul(s3a_r, K_B31);
      ST_B30:  mreq = mk_cmul(x_r, K_B30);
      ST_B32:  mreq = mk_cmul(s3b_r, K_B32);
      ST_FD:   mreq = mk_dmul(zf_r, fast_decay_r);
      ST_SD:   mreq = mk_dmul(zs_r, slow_decay_r);
      ST_FA:   mreq = mk_dmul(rect - zf_r, fast_attack_r);
      ST_SA:   mreq = mk_dmul(zf_r - zs_r, slow_attack_r);
      default: mreq = '0;
    endcase
  end

  // Each state consumes the product issued in the state before
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_r      <= in_channel;
          chaddr_r  <= raddr;
          inrange_r <= in_range;
          x_r       <= {{7{in_sample[23]}}, in_sample, 9'b0};
          y_r       <= '0;
          if (!in_range) zs_r <= '0;
        end
      end
      ST_LOAD: begin
        hp_r  <= ld.hp;
        s1a_r <= ld.s1a;
        s1b_r <= ld.s1b;
        s2a_r <= ld.s2a;
        s2b_r <= ld.s2b;
        s3a_r <= ld.s3a;
        s3b_r <= ld.s3b;
        zf_r  <= ld.zf;
        zs_r  <= ld.zs;
      end
      ST_A11: begin
        hp_r <= hp_n;
        x_r  <= x_hp;
      end
      ST_A12, ST_A22, ST_A32: acc_r <= x_sub;
      ST_A21: begin
        x_r   <= acc_sub_sat;
        s1b_r <= s1a_r;
        s1a_r <= acc_sub_sat;
      end
      ST_A31: begin
        x_r   <= acc_sub_sat;
        s2b_r <= s2a_r;
        s2a_r <= acc_sub_sat;
      end
      ST_B31: x_r <= acc_sub_sat;
      ST_B30: acc_r <= p_w;
      ST_B32: acc_r <= acc_add;
      ST_FD: begin
        y_r   <= acc_add_sat;
        s3b_r <= s3a_r;
        s3a_r <= x_r;
      end
      ST_SD: zf_r <= zf_r - prod[39:0];
      ST_FA: begin
        zs_r <= zs_r - prod[39:0];
        fa_r <= rect > zf_r;
      end
      ST_FADD: if (fa_r) zf_r <= zf_r + prod[39:0];
      ST_SA:   sa_r <= zf_r > zs_r;
      ST_SADD: if (sa_r) zs_r <= zs_r + prod[39:0];
      default: ;
    endcase
  end

  // Output rounding to Q5.23 with saturation
  logic [39:0] abs_y;
  logic [30:0] mag_w, mag_l;
  logic signed [27:0] weighted_c;
  logic [26:0]        level_c;

  always_comb begin
    abs_y = y_r[39] ? 40'(-y_r) : y_r;
    mag_w = 31'((41'(abs_y) + 41'd256) >> 9);
    mag_l = 31'((41'(zs_r) + 41'd256) >> 9);
    if (y_r[39]) weighted_c = 28'(-(mag_w > OUT_NEG_MAX ? OUT_NEG_MAX : mag_w));
    else         weighted_c = 28'(mag_w > OUT_POS_MAX ? OUT_POS_MAX : mag_w);
    level_c = 27'(mag_l > OUT_POS_MAX ? OUT_POS_MAX : mag_l);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && fin_go) begin
      out_channel_out <= ch_r;
      out_weighted    <= weighted_c;
      out_level       <= level_c;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_write_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_FIN) && inrange_r)
    else $error("state memory written outside the final step");

  a_det_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && inrange_r |-> !zf_r[39] && !zs_r[39])
    else $error("detector level left its range");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside the final step");

endmodule

`default_nettype wire

/* rtl/core/i468_mul.sv */
// ----------------------------------------------------------------------------
// i468_mul - shared multiplier with rounding
// Registers partial products, then rounds them back to Q8.32 next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i468_mul
  import i468_pkg::*;
(
  input  wire logic               clk,
  input  wire mul_req_t           req,
  output logic signed [41:0]      prod
);

  localparam logic [64:0] RND_C = 65'd1 << 29;
  localparam logic [64:0] RND_D = 65'd1 << 31;

  logic [63:0] p_lo_r;
  logic [39:0] p_hi_r;
  logic        neg_r;
  logic        dmode_r;

  logic [64:0] lo_c;
  logic [64:0] lo_d;
  logic [41:0] mag_c;
  logic [41:0] mag_d;
  logic [41:0] mag;

  // Partial products: low 32 bits and top byte of the operand
  always_ff @(posedge clk) begin
    p_lo_r  <= 64'(req.mag[31:0]) * 64'(req.coef);
    p_hi_r  <= 40'(req.mag[39:32]) * 40'(req.coef);
    neg_r   <= req.neg;
    dmode_r <= req.dmode;
  end

  // Filter products round ties away from zero, detector products ties up
  always_comb begin
    lo_c  = 65'(p_lo_r) + RND_C;
    lo_d  = 65'(p_lo_r) + RND_D;
    mag_c = {p_hi_r, 2'b00} + 42'(lo_c[64:30]);
    mag_d = 42'(p_hi_r) + 42'(lo_d[64:32]);
    mag   = dmode_r ? mag_d : mag_c;
    prod  = neg_r ? -$signed(mag) : $signed(mag);
  end

endmodule

`default_nettype wire

/* verif/tb_itur468_noise_meter_top.sv */
// ----------------------------------------------------------------------------
// tb_itur468_noise_meter_top - self-checking bench for the 468 noise meter
// Drives tagged Q1.23 samples through the valid/ready input channel and
// predicts the weighted value and slow detector level per transaction with
// a bit-exact model of the filter chain and both quasi-peak detectors.
// Results are checked in order, field by field. The detector rates are
// reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_itur468_noise_meter_top;
  import i468_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 8;
  localparam longint SAT_HI = 64'sd549755813887;
  localparam longint SAT_LO = -64'sd549755813888;
  localparam longint unsigned LO32 = 64'hFFFF_FFFF;

  typedef struct {
    logic [2:0]         ch;
    logic signed [27:0] weighted;
    logic [26:0]        level;
  } meter_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [2:0]                in_channel;
  logic signed [23:0]        in_sample;
  logic                      out_valid;
  logic                      out_ready;
  logic [2:0]                out_channel_out;
  logic signed [27:0]        out_weighted;
  logic [26:0]               out_level;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [31:0]               cfg_data;

  itur468_noise_meter_top #(.CHANNELS(NCH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel_out (out_channel_out),
    .out_weighted    (out_weighted),
    .out_level       (out_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Model copy of rates and per-channel state
  logic [31:0] rate_fa, rate_fd, rate_sa, rate_sd;
  longint hp_st [NCH];
  longint s1a [NCH], s1b [NCH], s2a [NCH], s2b [NCH], s3a [NCH], s3b [NCH];
  longint unsigned fast_lvl [NCH], slow_lvl [NCH];

  meter_result_t pending_results[$];
  int  fail_count = 0;
  bit  no_idle = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("tb_itur468_noise_meter_top failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------
  function automatic longint clip40(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Filter product, Q8.32 times Q2.30, rounded ties away from zero
  function automatic longint coef_mul(input longint s, input longint c);
    bit neg;
    longint unsigned us, uc, p;
    neg = (s < 0) != (c < 0);
    us  = (s < 0) ? longint'(-s) : s;
    uc  = (c < 0) ? longint'(-c) : c;
    p   = (((us >> 32) * uc) << 2) + ((((us & LO32) * uc) + (64'd1 << 29)) >> 30);
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // Detector product, value times Q0.32 rate, rounded ties up
  function automatic longint unsigned rate_mul(input longint unsigned v,
                                               input logic [31:0] k);
    longint unsigned kk;
    kk = k;
    return (v >> 32) * kk + ((((v & LO32) * kk) + (64'd1 << 31)) >> 32);
  endfunction

  // Weighting filter plus detectors for one sample; updates channel state
  function automatic meter_result_t weigh_sample(input logic [2:0] ch,
                                                 input logic signed [23:0] smp);
    meter_result_t res;
    longint x, d, y, r, mag;
    longint unsigned z1, z2, lev;
    res.ch = ch;
    res.weighted = '0;
    res.level = '0;
    if (ch >= NCH) return res;

    x = longint'(smp) * 512;
    d = clip40(x - hp_st[ch]);
    hp_st[ch] = clip40(hp_st[ch] + coef_mul(d, K_WHP));
    x = clip40(x - hp_st[ch]);

    x = clip40(x - coef_mul(s1a[ch], K_A11) - coef_mul(s1b[ch], K_A12));
    s1b[ch] = s1a[ch];
    s1a[ch] = x;

    x = clip40(x - coef_mul(s2a[ch], K_A21) - coef_mul(s2b[ch], K_A22));
    s2b[ch] = s2a[ch];
    s2a[ch] = x;

    x = clip40(x - coef_mul(s3a[ch], K_A31) - coef_mul(s3b[ch], K_A32));
    y = clip40(coef_mul(x, K_B30) + coef_mul(s3a[ch], K_B31) + coef_mul(s3b[ch], K_B32));
    s3b[ch] = s3a[ch];
    s3a[ch] = x;

    // Rectify, then fast and slow quasi-peak stages
    r = (y < 0) ? clip40(-y) : y;
    z1 = fast_lvl[ch];
    z1 -= rate_mul(z1, rate_fd);
    if (longint'(r) > longint'(z1)) z1 += rate_mul(longint'(r) - z1, rate_fa);
    fast_lvl[ch] = z1;

    z2 = slow_lvl[ch];
    z2 -= rate_mul(z2, rate_sd);
    if (z1 > z2) z2 += rate_mul(z1 - z2, rate_sa);
    slow_lvl[ch] = z2;

    mag = (((y < 0) ? -y : y) + 256) / 512;
    if (y < 0) begin
      if (mag > 134217728) mag = 134217728;
      mag = -mag;
    end else if (mag > 134217727) begin
      mag = 134217727;
    end
    res.weighted = mag[27:0];

    lev = (z2 + 256) >> 9;
    if (lev > 134217727) lev = 134217727;
    res.level = lev[26:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    meter_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: channel_out=%0d", out_channel_out);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_channel_out !== exp_r.ch) begin
          $error("channel_out: expected %0d, got %0d", exp_r.ch, out_channel_out);
          fail_count++;
        end
        if (out_weighted !== exp_r.weighted) begin
          $error("weighted: expected %0d, got %0d", exp_r.weighted, out_weighted);
          fail_count++;
        end
        if (out_level !== exp_r.level) begin
          $error("level: expected %0d, got %0d", exp_r.level, out_level);
          fail_count++;
        end
      end
    end
  end

  // Result-side back-pressure: held stretches of ready or stall
  always @(negedge clk) begin
    static int hold = 0;
    int pick;
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (hold > 0) begin
      hold--;
    end else begin
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 55) begin
        out_ready = 1'b1;
        hold = $urandom_range(0, 20);
      end else if (pick < 92) begin
        out_ready = 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_ready = 1'b0;
        hold = $urandom_range(10, 40);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; all entered and left just after a falling edge
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [2:0] ch, input logic signed [23:0] smp);
    int pick;
    pick = $urandom_range(0, 99);
    if (!no_idle) begin
      if (pick >= 92)      repeat ($urandom_range(8, 30)) @(negedge clk);
      else if (pick >= 60) repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_channel = ch;
    in_sample  = smp;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(weigh_sample(ch, smp));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_rate(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_FAST_ATTACK: rate_fa = val;
      CFG_FAST_DECAY:  rate_fd = val;
      CFG_SLOW_ATTACK: rate_sa = val;
      default:         rate_sd = val;
    endcase
  endtask

  task automatic set_rates(input logic [31:0] fa, input logic [31:0] fd,
                           input logic [31:0] sa, input logic [31:0] sd);
    drain_results();
    write_rate(CFG_FAST_ATTACK, fa);
    write_rate(CFG_FAST_DECAY, fd);
    write_rate(CFG_SLOW_ATTACK, sa);
    write_rate(CFG_SLOW_DECAY, sd);
  endtask

  function automatic logic signed [23:0] pick_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    if (pick < 40) return 24'($signed($urandom_range(0, 8191)) - 4096);
    return 24'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Maximum on every channel, other extremes, then a full-scale square wave
  task automatic test_directed_extremes();
    for (int c = 0; c < NCH; c++) send_sample(3'(c), 24'sh7FFFFF);
    send_sample(3'd0, 24'sh800000);
    send_sample(3'd7, 24'sh800000);
    send_sample(3'd1, 24'sh000000);
    send_sample(3'd2, -24'sd1);
    send_sample(3'd3, 24'sd1);
    for (int i = 0; i < 10; i++)
      send_sample(3'd5, (i % 2) ? 24'sh800000 : 24'sh7FFFFF);
  endtask

  // Rate extremes: all ones, all zeros, then a mixed setting
  task automatic test_rate_extremes();
    set_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 40; i++) send_sample(3'($urandom), pick_sample());
    set_rates('0, '0, '0, '0);
    for (int i = 0; i < 40; i++) send_sample(3'($urandom), pick_sample());
    set_rates(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0);
    for (int i = 0; i < 40; i++) send_sample(3'($urandom), pick_sample());
  endtask

  // Random traffic over several rate settings, idle-free stretches included
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0)
        set_rates(RST_FAST_ATTACK, RST_FAST_DECAY, RST_SLOW_ATTACK, RST_SLOW_DECAY);
      else
        set_rates($urandom, $urandom_range(0, 32'h00FF_FFFF), $urandom,
                  $urandom_range(0, 32'h000F_FFFF));
      for (int i = 0; i < 140; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
        send_sample(3'($urandom), pick_sample());
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_channel = '0;
    in_sample  = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rate_fa = RST_FAST_ATTACK;
    rate_fd = RST_FAST_DECAY;
    rate_sa = RST_SLOW_ATTACK;
    rate_sd = RST_SLOW_DECAY;
    for (int c = 0; c < NCH; c++) begin
      hp_st[c] = 0; s1a[c] = 0; s1b[c] = 0; s2a[c] = 0;
      s2b[c] = 0; s3a[c] = 0; s3b[c] = 0;
      fast_lvl[c] = 0; slow_lvl[c] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_rate_extremes();
    test_random_traffic();

    drain_results();
    if (fail_count == 0) begin
      $display("tb_itur468_noise_meter_top passed");
    end else begin
      $display("tb_itur468_noise_meter_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
